// ===== rtl/pair_weight_accumulate_table_defines.svh =====
// Assertion macros used by the pair weight table engine.
`ifndef PAIR_WEIGHT_ACCUMULATE_TABLE_DEFINES_SVH
`define PAIR_WEIGHT_ACCUMULATE_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PWAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PWAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwat_pkg.sv =====
// Package with shared types and constants for the pair weight table.
`default_nettype none

package pwat_pkg;

  // Default sizing
  localparam int unsigned DEF_TABLE_DEPTH = 4096;
  localparam int unsigned DEF_INDEX_BITS  = 15;

  // Fixed field widths
  localparam int unsigned IDX_W = 15;
  localparam int unsigned WT_W  = 32;

  // Load threshold: count * PCT_SCALE >= depth * LOAD_PCT
  localparam int unsigned LOAD_PCT  = 65;
  localparam int unsigned PCT_SCALE = 100;

  // Saturation bounds for signed Q16.16
  localparam logic [WT_W-1:0] WT_MAX = 32'h7FFF_FFFF;
  localparam logic [WT_W-1:0] WT_MIN = 32'h8000_0000;

  // Action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_SAME     = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_LOOKUP   = 3'd4
  } pwat_status_e;

  // One input beat
  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic [WT_W-1:0]  delta;
  } pwat_req_t;

  // One result beat
  typedef struct packed {
    logic [WT_W-1:0] weight;
    logic            found;
    pwat_status_e    status;
    logic            load_high;
  } pwat_res_t;

  // Engine status toward the channel logic
  typedef struct packed {
    logic idle;
    logic done;
  } pwat_stat_t;

  // Probe compare flags from the arithmetic unit
  typedef struct packed {
    logic empty;
    logic hit;
  } pwat_flag_t;

endpackage

`default_nettype wire

// ===== rtl/pwat_alu.sv =====
// Shared arithmetic unit: slot key compare and saturating weight add.
`default_nettype none

module pwat_alu
  import pwat_pkg::*;
#(
  parameter int unsigned KEY_W = 2 * DEF_INDEX_BITS
) (
  input  logic [WT_W-1:0]  stored_wt_i,
  input  logic [WT_W-1:0]  delta_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] slot_key_i,
  output logic [WT_W-1:0]  sum_o,
  output pwat_flag_t       flag_o
);

  logic [WT_W:0] sum_wide;

  // Slot classification: zero key marks an empty slot
  always_comb begin
    flag_o.empty = (slot_key_i == '0);
    flag_o.hit   = !flag_o.empty && (slot_key_i == key_i);
  end

  // Sign-extended add, clamp on overflow
  assign sum_wide = {stored_wt_i[WT_W-1], stored_wt_i} + {delta_i[WT_W-1], delta_i};

  always_comb begin
    if (sum_wide[WT_W] != sum_wide[WT_W-1]) begin
      sum_o = sum_wide[WT_W] ? WT_MIN : WT_MAX;
    end else begin
      sum_o = sum_wide[WT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pwat_engine.sv =====
// Probe sequencer with the key and weight stores of the pair weight table.
`default_nettype none

`include "pair_weight_accumulate_table_defines.svh"

module pwat_engine
  import pwat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  pwat_req_t  req_i,
  input  logic       take_i,
  output pwat_stat_t stat_o,
  output pwat_res_t  res_o
);

  localparam int unsigned SLOT_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W      = 2 * INDEX_BITS;
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MODC_W     = $clog2(KEY_W);
  localparam bit          IS_POW2    = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam int unsigned LOAD_LIMIT = (TABLE_DEPTH * LOAD_PCT + PCT_SCALE - 1) / PCT_SCALE;
  localparam int unsigned LAST_SLOT  = TABLE_DEPTH - 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  state_e              state_q;
  logic                action_q;
  logic [KEY_W-1:0]    key_q;
  logic [WT_W-1:0]     delta_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   probe_q;
  logic [CNT_W-1:0]    count_q;
  logic [SLOT_W-1:0]   mod_rem_q;
  logic [KEY_W-1:0]    mod_sh_q;
  logic [MODC_W-1:0]   mod_cnt_q;
  pwat_res_t           res_q;

  // Stores and their registered read data
  logic [KEY_W-1:0]    slot_keys [TABLE_DEPTH];
  logic [WT_W-1:0]     slot_weights [TABLE_DEPTH];
  logic [KEY_W-1:0]    rd_key_q;
  logic [WT_W-1:0]     rd_wt_q;

  logic [INDEX_BITS-1:0] idx_a, idx_b, idx_lo, idx_hi;
  logic [KEY_W-1:0]    key_in;
  logic                same_in;
  logic [SLOT_W:0]     mod_shift;
  logic                mod_ge;
  logic [SLOT_W-1:0]   mod_next;
  logic [SLOT_W-1:0]   next_slot;
  logic                at_last;
  logic [WT_W-1:0]     sat_sum;
  pwat_flag_t          alu_flag;
  logic                key_we;
  logic [KEY_W-1:0]    key_wd;
  logic                wt_we;
  logic [WT_W-1:0]     wt_wd;

  // Order the pair and pack the key
  always_comb begin
    idx_a   = INDEX_BITS'(req_i.first_index);
    idx_b   = INDEX_BITS'(req_i.second_index);
    idx_lo  = (idx_a < idx_b) ? idx_a : idx_b;
    idx_hi  = (idx_a < idx_b) ? idx_b : idx_a;
    key_in  = {idx_lo, idx_hi};
    same_in = (idx_a == idx_b);
  end

  // One restoring step of key mod depth, MSB first
  always_comb begin
    mod_shift = {mod_rem_q, mod_sh_q[KEY_W-1]};
    mod_ge    = (mod_shift >= (SLOT_W + 1)'(TABLE_DEPTH));
    mod_next  = mod_ge ? SLOT_W'(mod_shift - (SLOT_W + 1)'(TABLE_DEPTH)) : SLOT_W'(mod_shift);
  end

  // Probe stepping with wrap
  assign at_last   = (probe_q == SLOT_W'(LAST_SLOT));
  assign next_slot = (slot_q == SLOT_W'(LAST_SLOT)) ? '0 : slot_q + 1'b1;

  pwat_alu #(
    .KEY_W (KEY_W)
  ) u_alu (
    .stored_wt_i (rd_wt_q),
    .delta_i     (delta_q),
    .key_i       (key_q),
    .slot_key_i  (rd_key_q),
    .sum_o       (sat_sum),
    .flag_o      (alu_flag)
  );

  // Store write controls: clear sweep, insert or update
  always_comb begin
    key_we = (state_q == S_CLEAR) ||
             ((state_q == S_CHECK) && alu_flag.empty && (action_q == ACT_ADD));
    key_wd = (state_q == S_CLEAR) ? '0 : key_q;
    wt_we  = (state_q == S_CHECK) && (action_q == ACT_ADD) &&
             (alu_flag.empty || alu_flag.hit);
    wt_wd  = alu_flag.hit ? sat_sum : delta_q;
  end

  // Key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      slot_keys[slot_q] <= key_wd;
    end
    if (state_q == S_READ) begin
      rd_key_q <= slot_keys[slot_q];
    end
  end

  // Weight store
  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      slot_weights[slot_q] <= wt_wd;
    end
    if (state_q == S_READ) begin
      rd_wt_q <= slot_weights[slot_q];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      action_q  <= ACT_ADD;
      key_q     <= '0;
      delta_q   <= '0;
      slot_q    <= '0;
      probe_q   <= '0;
      count_q   <= '0;
      mod_rem_q <= '0;
      mod_sh_q  <= '0;
      mod_cnt_q <= '0;
      res_q     <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (slot_q == SLOT_W'(LAST_SLOT)) begin
            slot_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            action_q  <= req_i.action;
            key_q     <= key_in;
            delta_q   <= req_i.delta;
            probe_q   <= '0;
            mod_rem_q <= '0;
            mod_sh_q  <= key_in;
            mod_cnt_q <= '0;
            if (same_in) begin
              res_q.weight    <= '0;
              res_q.found     <= 1'b0;
              res_q.status    <= (req_i.action == ACT_LOOKUP) ? STAT_LOOKUP : STAT_SAME;
              res_q.load_high <= 1'b0;
              state_q         <= S_DONE;
            end else if (IS_POW2) begin
              slot_q  <= SLOT_W'(key_in);
              state_q <= S_READ;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          mod_rem_q <= mod_next;
          mod_sh_q  <= mod_sh_q << 1;
          mod_cnt_q <= mod_cnt_q + 1'b1;
          if (mod_cnt_q == MODC_W'(KEY_W - 1)) begin
            slot_q  <= mod_next;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          res_q.load_high <= 1'b0;
          if (alu_flag.empty) begin
            res_q.found <= 1'b0;
            if (action_q == ACT_LOOKUP) begin
              res_q.weight <= '0;
              res_q.status <= STAT_LOOKUP;
            end else begin
              res_q.weight <= delta_q;
              res_q.status <= STAT_INSERTED;
              count_q      <= count_q + 1'b1;
            end
            state_q <= S_DONE;
          end else if (alu_flag.hit) begin
            res_q.found <= 1'b1;
            if (action_q == ACT_LOOKUP) begin
              res_q.weight <= rd_wt_q;
              res_q.status <= STAT_LOOKUP;
            end else begin
              res_q.weight <= sat_sum;
              res_q.status <= STAT_UPDATED;
            end
            state_q <= S_DONE;
          end else if (at_last) begin
            // every slot probed, no match and no room
            res_q.weight <= '0;
            res_q.found  <= 1'b0;
            res_q.status <= (action_q == ACT_LOOKUP) ? STAT_LOOKUP : STAT_FULL;
            state_q      <= S_DONE;
          end else begin
            probe_q <= probe_q + 1'b1;
            slot_q  <= next_slot;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Status and result toward the channel logic
  always_comb begin
    stat_o.idle     = (state_q == S_IDLE);
    stat_o.done     = (state_q == S_DONE);
    res_o           = res_q;
    res_o.load_high = (count_q >= CNT_W'(LOAD_LIMIT));
  end

  `PWAT_ASSERT_NEXT(a_insert_counts, (state_q == S_CHECK) && alu_flag.empty && (action_q == ACT_ADD), count_q == $past(count_q) + 1'b1, "insert did not bump entry count")
  `PWAT_ASSERT_IMPL(a_found_status, (state_q == S_DONE) && res_q.found, (res_q.status == STAT_UPDATED) || (res_q.status == STAT_LOOKUP), "found set with wrong status")
  `PWAT_ASSERT_IMPL(a_key_nonzero, key_we && (state_q != S_CLEAR), key_wd != '0, "insert wrote the empty key")
  `PWAT_ASSERT_IMPL(a_count_bound, state_q == S_CHECK, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")

endmodule

`default_nettype wire

// ===== rtl/pair_weight_accumulate_table.sv =====
// Top level of the pair weight table: channel handshakes and result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | action, first_index, second_index, delta
//  out     | output    | out_valid_o / out_ready_i| weight, found, status, load_high
//
// Each probed slot is read, then compared (S_READ, S_CHECK); a depth that
// is not a power of two first reduces the key modulo the depth in S_MOD,
// one key bit per step, to find the start slot. Equal indices skip the probe.
// After reset the key store is swept to empty, slot by slot, with
// in_ready_o low. One item is in work at a time; a finished beat waits in
// the output register, so the next item is taken while out_ready_i is low.
`default_nettype none

module pair_weight_accumulate_table
  import pwat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [IDX_W-1:0] first_index_i,
  input  logic [IDX_W-1:0] second_index_i,
  input  logic [WT_W-1:0]  delta_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WT_W-1:0]  weight_o,
  output logic             found_o,
  output logic [2:0]       status_o,
  output logic             load_high_o
);

  pwat_req_t  req;
  pwat_stat_t eng_stat;
  pwat_res_t  eng_res;
  pwat_res_t  out_res_q;
  logic       out_valid_q;
  logic       start;
  logic       take;

  // Input beat
  always_comb begin
    req.action       = action_i;
    req.first_index  = first_index_i;
    req.second_index = second_index_i;
    req.delta        = delta_i;
  end

  assign in_ready_o = eng_stat.idle;
  assign start      = in_valid_i && in_ready_o;
  assign take       = eng_stat.done && (!out_valid_q || out_ready_i);

  pwat_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .take_i  (take),
    .stat_o  (eng_stat),
    .res_o   (eng_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        out_res_q   <= eng_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign weight_o    = out_res_q.weight;
  assign found_o     = out_res_q.found;
  assign status_o    = out_res_q.status;
  assign load_high_o = out_res_q.load_high;

endmodule

`default_nettype wire

// ===== bench/pwat_table_mirror.sv =====
// Table mirror: tracks the pair weight store, predicts each result beat and compares it.
module pwat_table_mirror
  import pwat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             action_i,
  input  logic [IDX_W-1:0] first_index_i,
  input  logic [IDX_W-1:0] second_index_i,
  input  logic [WT_W-1:0]  delta_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [WT_W-1:0]  weight_i,
  input  logic             found_i,
  input  logic [2:0]       status_i,
  input  logic             load_high_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      occupied_o
);

  // Only the first REPORT_CAP mismatches get a line; all of them are counted
  localparam int unsigned REPORT_CAP = 40;

  // Shadow copy of the store; a zero key marks an empty slot
  logic [2*IDX_W-1:0] slot_key    [TABLE_DEPTH];
  logic [WT_W-1:0]    slot_weight [TABLE_DEPTH];
  pwat_res_t          due_results [$];
  pwat_res_t          oldest;

  // One line per mismatch up to REPORT_CAP, plus the count handed to the top
  task automatic report_mismatch(input string what, input logic [WT_W-1:0] got,
                                 input logic [WT_W-1:0] want);
    if (errors_o < REPORT_CAP) begin
      $display("%0t: result %0d: %s got %h want %h", $time, checked_o, what, got, want);
    end
    errors_o++;
  endtask

  // Apply one add or lookup to the shadow store and return the beat it yields
  function automatic pwat_res_t apply_pair_op(input logic act, input logic [IDX_W-1:0] a,
                                              input logic [IDX_W-1:0] b,
                                              input logic [WT_W-1:0] d);
    logic [IDX_W-1:0]     lo;
    logic [IDX_W-1:0]     hi;
    logic [2*IDX_W-1:0]   key;
    logic signed [WT_W:0] sum;
    int unsigned          slot;
    int unsigned          probes;
    bit                   hit;
    bit                   vacant;
    pwat_res_t            res;
    res    = '0;
    lo     = (a < b) ? a : b;
    hi     = (a < b) ? b : a;
    key    = {lo, hi};
    hit    = 1'b0;
    vacant = 1'b0;
    probes = 0;
    slot   = key % TABLE_DEPTH;
    // Linear probe with wrap; stops on the key or the first empty slot
    if (a != b) begin
      while (!hit && !vacant && probes < TABLE_DEPTH) begin
        if (slot_key[slot] == '0) begin
          vacant = 1'b1;
        end else if (slot_key[slot] == key) begin
          hit = 1'b1;
        end else begin
          slot = (slot + 1) % TABLE_DEPTH;
          probes++;
        end
      end
    end
    if (act == ACT_LOOKUP) begin
      // equal indices never probe, so they read back as absent
      res.status = STAT_LOOKUP;
      if (hit) begin
        res.weight = slot_weight[slot];
        res.found  = 1'b1;
      end
    end else if (a == b) begin
      res.status = STAT_SAME;
    end else if (hit) begin
      // saturating accumulate into the stored weight
      sum = $signed({slot_weight[slot][WT_W-1], slot_weight[slot]}) + $signed({d[WT_W-1], d});
      if (sum > $signed({1'b0, WT_MAX})) begin
        slot_weight[slot] = WT_MAX;
      end else if (sum < $signed({1'b1, WT_MIN})) begin
        slot_weight[slot] = WT_MIN;
      end else begin
        slot_weight[slot] = sum[WT_W-1:0];
      end
      res.weight = slot_weight[slot];
      res.found  = 1'b1;
      res.status = STAT_UPDATED;
    end else if (vacant) begin
      slot_key[slot]    = key;
      slot_weight[slot] = d;
      occupied_o++;
      res.weight = d;
      res.status = STAT_INSERTED;
    end else begin
      res.status = STAT_FULL;
    end
    res.load_high = (occupied_o * PCT_SCALE) >= (TABLE_DEPTH * LOAD_PCT);
    return res;
  endfunction

  // Predict on every input beat, compare on every result beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_DEPTH; s++) begin
        slot_key[s]    = '0;
        slot_weight[s] = '0;
      end
      due_results.delete();
      errors_o   = 0;
      pending_o  = 0;
      checked_o  = 0;
      occupied_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due_results.push_back(apply_pair_op(action_i, first_index_i, second_index_i, delta_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("beat with nothing due, weight", weight_i, '0);
        end else begin
          oldest = due_results.pop_front();
          if (weight_i !== oldest.weight) report_mismatch("weight", weight_i, oldest.weight);
          if (found_i !== oldest.found) report_mismatch("found", found_i, oldest.found);
          if (status_i !== oldest.status) report_mismatch("status", status_i, oldest.status);
          if (load_high_i !== oldest.load_high) begin
            report_mismatch("load_high", load_high_i, oldest.load_high);
          end
          checked_o++;
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== bench/tb_pair_weight_accumulate_table.sv =====
// Testbench top: clock, reset, beat traffic on both channels, watchdog and verdict.
module tb_pair_weight_accumulate_table;
  import pwat_pkg::*;

  localparam int unsigned TABLE_DEPTH   = DEF_TABLE_DEPTH;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned POOL_SIZE     = 12;
  localparam int unsigned CHOKE_AT      = 60;
  localparam int unsigned CHOKE_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  // a full-table probe reads and compares every slot; allow several of those
  localparam int unsigned STUCK_LIMIT   = 60000;

  logic             clk_i;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             action_i       = ACT_ADD;
  logic [IDX_W-1:0] first_index_i  = '0;
  logic [IDX_W-1:0] second_index_i = '0;
  logic [WT_W-1:0]  delta_i        = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [WT_W-1:0]  weight_o;
  logic             found_o;
  logic [2:0]       status_o;
  logic             load_high_o;

  int unsigned      errors;
  int unsigned      pending;
  int unsigned      checked;
  int unsigned      occupied;

  int unsigned      beats_sent   = 0;
  int unsigned      tx_run_left  = 0;
  int unsigned      stuck_cycles = 0;
  logic [IDX_W-1:0] pool [POOL_SIZE];

  pair_weight_accumulate_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (DEF_INDEX_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .delta_i        (delta_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .weight_o       (weight_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .load_high_o    (load_high_o)
  );

  pwat_table_mirror #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table_mirror (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .delta_i        (delta_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .weight_i       (weight_o),
    .found_i        (found_o),
    .status_i       (status_o),
    .load_high_i    (load_high_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked),
    .occupied_o     (occupied)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q16.16 deltas: small values, full random, and the saturation extremes
  function automatic logic [WT_W-1:0] pick_delta();
    int unsigned roll;
    logic [19:0] frac;
    roll = $urandom_range(0, 99);
    frac = 20'($urandom);
    if (roll < 50) return {{(WT_W-20){frac[19]}}, frac};
    if (roll < 85) return WT_W'($urandom);
    if (roll < 93) return WT_MAX;
    return WT_MIN;
  endfunction

  // Offer one beat and hold it until accepted; valid stays high if no gap follows
  task automatic send_beat(input logic act, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input logic [WT_W-1:0] d);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    first_index_i  <= a;
    second_index_i <= b;
    delta_i        <= d;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (tx_run_left != 0) begin
      tx_run_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) tx_run_left = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, runs without stalls, and one long hold-off
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    int unsigned rx_run_left;
    bit          choked;
    taken       = 0;
    rx_run_left = 0;
    choked      = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (!choked && taken == CHOKE_AT) begin
        // block fills up behind this and must drop in_ready_o
        choked = 1'b1;
        out_ready_i <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
      end else begin
        if (rx_run_left != 0) begin
          rx_run_left--;
          stall = 0;
        end else begin
          stall = pick_gap();
          if ($urandom_range(0, 19) == 0) rx_run_left = $urandom_range(10, 30);
        end
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results still due", stuck_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned      roll;
    int unsigned      random_done;
    logic             act;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [WT_W-1:0]  d;

    // pool indices all land their pairs in the top slots of the table
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool[k] = IDX_W'(($urandom_range(0, 7) << 12) | 32'hF80 | $urandom_range(0, 127));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners
    send_beat(ACT_LOOKUP, 15'h0005, 15'h0009, 32'h0000_0000);  // absent on empty table
    send_beat(ACT_ADD,    15'h0000, 15'h7FFF, WT_MAX);         // insert, index extremes
    send_beat(ACT_ADD,    15'h7FFF, 15'h0000, WT_MAX);         // swapped order, clamp high
    send_beat(ACT_LOOKUP, 15'h7FFF, 15'h0000, 32'hFFFF_FFFF);
    send_beat(ACT_ADD,    15'h1234, 15'h0567, WT_MIN);
    send_beat(ACT_ADD,    15'h0567, 15'h1234, WT_MIN);         // clamp low
    send_beat(ACT_ADD,    15'h1234, 15'h0567, WT_MAX);         // back to -1 lsb
    send_beat(ACT_ADD,    15'h7FFF, 15'h7FFF, 32'h0001_0000);  // equal indices, ignored
    send_beat(ACT_ADD,    15'h0000, 15'h0000, WT_MIN);
    send_beat(ACT_LOOKUP, 15'h2AAA, 15'h2AAA, 32'h0000_0000);  // equal indices lookup
    send_beat(ACT_ADD,    15'h5555, 15'h2AAA, 32'h0000_0000);  // insert zero weight
    send_beat(ACT_ADD,    15'h2AAA, 15'h5555, 32'h0000_0001);
    send_beat(ACT_ADD,    15'h5555, 15'h2AAA, 32'hFFFF_FFFF);
    send_beat(ACT_ADD,    15'h0001, 15'h0FFF, 32'h0002_8000);  // same home as last slot: wraps
    send_beat(ACT_LOOKUP, 15'h0FFF, 15'h0001, 32'h0000_0000);
    send_beat(ACT_ADD,    15'h0002, 15'h1FFF, 32'h0001_0000);  // longer probe past the wrap
    send_beat(ACT_LOOKUP, 15'h0003, 15'h2FFF, 32'h0000_0000);  // absent, probe ends on empty
    send_beat(ACT_ADD,    15'h7FFE, 15'h7FFF, 32'hFFFF_0000);
    send_beat(ACT_LOOKUP, 15'h7FFF, 15'h7FFE, 32'h1234_5678);

    // Random traffic: mostly pool pairs so updates and probe chains happen
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      a    = pool[$urandom_range(0, POOL_SIZE - 1)];
      b    = pool[$urandom_range(0, POOL_SIZE - 1)];
      d    = pick_delta();
      act  = ACT_ADD;
      if (roll < 55) begin
        act = ACT_ADD;
      end else if (roll < 80) begin
        act = ACT_LOOKUP;
      end else if (roll < 88) begin
        act = ACT_LOOKUP;
        a   = IDX_W'($urandom);
        b   = IDX_W'($urandom);
      end else if (roll < 95) begin
        act = ($urandom_range(0, 1) != 0) ? ACT_LOOKUP : ACT_ADD;
        a   = IDX_W'($urandom);
        b   = a;
      end else begin
        a = IDX_W'($urandom);
        b = IDX_W'($urandom);
      end
      send_beat(act, a, b, d);
      if (a != b) random_done++;
    end
    drain();

    // Closing ops: fresh pairs, pool updates and absent lookups
    send_beat(ACT_ADD,    15'h0005, 15'h6000, 32'h0001_0000);
    send_beat(ACT_ADD,    15'h0000, IDX_W'(TABLE_DEPTH), WT_MAX);
    send_beat(ACT_LOOKUP, 15'h0000, IDX_W'(TABLE_DEPTH + 1), 32'h0000_0000);
    send_beat(ACT_LOOKUP, 15'h0007, 15'h5001, 32'h0000_0000);
    send_beat(ACT_ADD,    15'h7FFF, 15'h7FFF, 32'h0000_0001);
    send_beat(ACT_ADD,    15'h7000, 15'h7001, WT_MIN);
    send_beat(ACT_ADD,    pool[0], pool[1], WT_MAX);
    send_beat(ACT_LOOKUP, pool[1], pool[0], 32'h0000_0000);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d input beats: corners, pool traffic with a long output stall,",
             beats_sent);
    $display("and closing adds and lookups; %0d of %0d slots in use, %0d results compared",
             occupied, TABLE_DEPTH, checked);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
